FILE: hdl/grid_block_partitioner_defines.svh
// Assertion macros used by the partitioner controller.
`ifndef GRID_BLOCK_PARTITIONER_DEFINES_SVH
`define GRID_BLOCK_PARTITIONER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property with reset disabling the check.
`define GBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define GBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBP_ASSERT(label, prop, msg)
`define GBP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hdl/gbp_pkg.sv
package gbp_pkg;

  localparam int DATA_W       = 16;
  localparam int DIM_W        = 2;
  localparam int MAX_DIMS     = 3;
  localparam int NUM_DIMS_DEF = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int DIV_CNT_W    = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             topo_init;
    logic             topo_mul;
    logic             topo_chk;
    logic             valid_chk;
    logic             div_load;
    logic             div_step;
    logic             mul_qp;
    logic             mul_pb;
    logic             mul_bt;
    logic             dim_next;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] dim;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;
    logic valid;
  } sts_t;

endpackage

FILE: hdl/grid_block_partitioner.sv
// Channel   Ports                                   Beat taken when
// config    cfg_we, cfg_index, cfg_data             cfg_we high
// input     start, busy, part_x/y/z                 start high and busy low
// result    done, index_valid, topo_*, size_*,      done high (one cycle)
//           offset_*, flat_index
//
// One beat is in flight at a time. The topology search runs each trial through
// the shared multiplier, then a compare; a valid index then splits each
// dimension with the 16-step restoring divider; an invalid one skips the split.
// Synchronous active-high reset returns the block to idle and sets every
// configuration register to 1. Results cannot be held off by the receiver.
module grid_block_partitioner #(
  parameter int NUM_DIMS = gbp_pkg::NUM_DIMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [gbp_pkg::DATA_W-1:0]    part_x,
  input  logic [gbp_pkg::DATA_W-1:0]    part_y,
  input  logic [gbp_pkg::DATA_W-1:0]    part_z,
  output logic                          done,
  output logic                          index_valid,
  output logic [gbp_pkg::DATA_W-1:0]    topo_x,
  output logic [gbp_pkg::DATA_W-1:0]    topo_y,
  output logic [gbp_pkg::DATA_W-1:0]    topo_z,
  output logic [gbp_pkg::DATA_W-1:0]    size_x,
  output logic [gbp_pkg::DATA_W-1:0]    size_y,
  output logic [gbp_pkg::DATA_W-1:0]    size_z,
  output logic [gbp_pkg::DATA_W-1:0]    offset_x,
  output logic [gbp_pkg::DATA_W-1:0]    offset_y,
  output logic [gbp_pkg::DATA_W-1:0]    offset_z,
  output logic [gbp_pkg::DATA_W-1:0]    flat_index
);

  gbp_pkg::cmd_t cmd;
  gbp_pkg::sts_t sts;

  // Sequencer.
  gbp_ctrl #(.NUM_DIMS(NUM_DIMS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Registers, divider and multiplier.
  gbp_datapath #(.NUM_DIMS(NUM_DIMS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .part_x      (part_x),
    .part_y      (part_y),
    .part_z      (part_z),
    .cmd         (cmd),
    .sts         (sts),
    .index_valid (index_valid),
    .topo_x      (topo_x),
    .topo_y      (topo_y),
    .topo_z      (topo_z),
    .size_x      (size_x),
    .size_y      (size_y),
    .size_z      (size_z),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .offset_z    (offset_z),
    .flat_index  (flat_index)
  );

endmodule

FILE: hdl/gbp_ctrl.sv
`include "grid_block_partitioner_defines.svh"

module gbp_ctrl #(
  parameter int NUM_DIMS = gbp_pkg::NUM_DIMS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output gbp_pkg::cmd_t cmd,
  input  gbp_pkg::sts_t sts
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_TINIT  = 12'b0000_0000_0010,
    S_TMUL   = 12'b0000_0000_0100,
    S_TCHK   = 12'b0000_0000_1000,
    S_VCHK   = 12'b0000_0001_0000,
    S_DLOAD  = 12'b0000_0010_0000,
    S_DSTEP  = 12'b0000_0100_0000,
    S_MQP    = 12'b0000_1000_0000,
    S_MPB    = 12'b0001_0000_0000,
    S_MBT    = 12'b0010_0000_0000,
    S_DNEXT  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  localparam logic [gbp_pkg::DIM_W-1:0] LAST_DIM = gbp_pkg::DIM_W'(NUM_DIMS - 1);

  state_t                          state, state_next;
  logic [gbp_pkg::DIM_W-1:0]       k, k_next;
  logic [gbp_pkg::DIM_W-1:0]       dim, dim_next;
  logic [gbp_pkg::DIV_CNT_W-1:0]   div_cnt, div_cnt_next;

  // Sequencing of search, index check and per-dimension split.
  always_comb begin
    state_next   = state;
    k_next       = k;
    dim_next     = dim;
    div_cnt_next = div_cnt;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_TINIT;
      end
      S_TINIT: begin
        k_next     = '0;
        state_next = S_TMUL;
      end
      S_TMUL: state_next = S_TCHK;
      S_TCHK: begin
        if (sts.fits) begin
          k_next     = '0;
          state_next = S_TMUL;
        end else if (k == LAST_DIM) begin
          state_next = S_VCHK;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_TMUL;
        end
      end
      S_VCHK: begin
        dim_next   = '0;
        state_next = sts.valid ? S_DLOAD : S_DONE;
      end
      S_DLOAD: begin
        div_cnt_next = '0;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == '1) state_next = S_MQP;
      end
      S_MQP: state_next = S_MPB;
      S_MPB: state_next = S_MBT;
      S_MBT: state_next = S_DNEXT;
      S_DNEXT: begin
        if (dim == LAST_DIM) begin
          state_next = S_DONE;
        end else begin
          dim_next   = dim + 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= '0;
      dim     <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      dim     <= dim_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && start;
    cmd.topo_init = (state == S_TINIT);
    cmd.topo_mul  = (state == S_TMUL);
    cmd.topo_chk  = (state == S_TCHK);
    cmd.valid_chk = (state == S_VCHK);
    cmd.div_load  = (state == S_DLOAD);
    cmd.div_step  = (state == S_DSTEP);
    cmd.mul_qp    = (state == S_MQP);
    cmd.mul_pb    = (state == S_MPB);
    cmd.mul_bt    = (state == S_MBT);
    cmd.dim_next  = (state == S_DNEXT);
    cmd.k         = k;
    cmd.dim       = dim;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `GBP_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `GBP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not start work")
  `GBP_ASSERT(a_done_idle, done |=> !busy, "block not idle after result")
  `GBP_ASSERT(a_k_range, busy |-> (k <= LAST_DIM), "search rank out of range")
  `GBP_ASSERT_ALWAYS(a_rst_idle, rst |=> !busy, "reset did not return to idle")

endmodule

FILE: hdl/gbp_datapath.sv
module gbp_datapath #(
  parameter int NUM_DIMS = gbp_pkg::NUM_DIMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbp_pkg::DATA_W-1:0]      cfg_data,
  input  logic [gbp_pkg::DATA_W-1:0]      part_x,
  input  logic [gbp_pkg::DATA_W-1:0]      part_y,
  input  logic [gbp_pkg::DATA_W-1:0]      part_z,
  input  gbp_pkg::cmd_t                   cmd,
  output gbp_pkg::sts_t                   sts,
  output logic                            index_valid,
  output logic [gbp_pkg::DATA_W-1:0]      topo_x,
  output logic [gbp_pkg::DATA_W-1:0]      topo_y,
  output logic [gbp_pkg::DATA_W-1:0]      topo_z,
  output logic [gbp_pkg::DATA_W-1:0]      size_x,
  output logic [gbp_pkg::DATA_W-1:0]      size_y,
  output logic [gbp_pkg::DATA_W-1:0]      size_z,
  output logic [gbp_pkg::DATA_W-1:0]      offset_x,
  output logic [gbp_pkg::DATA_W-1:0]      offset_y,
  output logic [gbp_pkg::DATA_W-1:0]      offset_z,
  output logic [gbp_pkg::DATA_W-1:0]      flat_index
);

  localparam int W  = gbp_pkg::DATA_W;
  localparam int ND = gbp_pkg::MAX_DIMS;
  localparam int DW = gbp_pkg::DIM_W;

  logic [W-1:0]   node_count;
  logic [W-1:0]   cells [ND];
  logic [W-1:0]   topo  [ND];
  logic [W-1:0]   part  [ND];
  logic [W-1:0]   size  [ND];
  logic [W-1:0]   offs  [ND];
  logic [W-1:0]   cur_prod;
  logic [2*W-1:0] mul_q;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [W-1:0]   base;
  logic [W-1:0]   flat;
  logic           valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= W'(1);
      for (int d = 0; d < ND; d++) cells[d] <= W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        gbp_pkg::REG_NODE_COUNT: node_count <= cfg_data;
        gbp_pkg::REG_CELLS_X:    cells[0]   <= cfg_data;
        gbp_pkg::REG_CELLS_Y:    cells[1]   <= cfg_data;
        gbp_pkg::REG_CELLS_Z:    cells[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rank each dimension by size, ties to the lower index, and pick rank k.
  logic [DW-1:0] rank [ND];
  logic [DW-1:0] pick;
  always_comb begin
    pick = '0;
    for (int d = 0; d < ND; d++) begin
      rank[d] = '0;
      for (int e = 0; e < ND; e++) begin
        if (e < NUM_DIMS && e != d &&
            ((topo[e] < topo[d]) || (topo[e] == topo[d] && e < d)))
          rank[d] = rank[d] + 1'b1;
      end
    end
    for (int d = 0; d < ND; d++) begin
      if (d < NUM_DIMS && rank[d] == cmd.k) pick = DW'(d);
    end
  end

  // The grown product equals the current one plus the product of the others.
  logic [W-1:0] oth_a, oth_b;
  always_comb begin
    case (pick)
      2'd0:    begin oth_a = topo[1]; oth_b = topo[2]; end
      2'd1:    begin oth_a = topo[0]; oth_b = topo[2]; end
      default: begin oth_a = topo[0]; oth_b = topo[1]; end
    endcase
  end

  // Shared multiplier operand select.
  logic [W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = oth_a;
    mul_b = oth_b;
    if (cmd.mul_qp) begin
      mul_a = quo;
      mul_b = part[cmd.dim];
    end else if (cmd.mul_pb) begin
      mul_a = part[cmd.dim];
      mul_b = base;
    end else if (cmd.mul_bt) begin
      mul_a = base;
      mul_b = topo[cmd.dim];
    end
  end

  logic [2*W:0] grown;
  assign grown    = (2*W+1)'(cur_prod) + (2*W+1)'(mul_q);
  assign sts.fits = (grown <= (2*W+1)'(node_count));

  // Index check against the topology.
  always_comb begin
    sts.valid = 1'b1;
    for (int d = 0; d < ND; d++) begin
      if (d < NUM_DIMS && part[d] >= topo[d]) sts.valid = 1'b0;
    end
  end

  // One restoring divider step.
  logic [W:0] trial;
  logic       take;
  assign trial = {rem, quo[W-1]};
  assign take  = (trial >= {1'b0, topo[cmd.dim]});

  logic [W-1:0] rmd, cur_part;
  assign rmd      = rem;
  assign cur_part = part[cmd.dim];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      part[0] <= part_x;
      part[1] <= part_y;
      part[2] <= part_z;
    end
    if (cmd.topo_mul || cmd.mul_qp || cmd.mul_pb || cmd.mul_bt)
      mul_q <= mul_a * mul_b;
    if (cmd.topo_init) begin
      for (int d = 0; d < ND; d++) topo[d] <= W'(1);
      cur_prod <= W'(1);
    end
    if (cmd.topo_chk && sts.fits) begin
      topo[pick] <= topo[pick] + 1'b1;
      cur_prod   <= grown[W-1:0];
    end
    if (cmd.valid_chk) begin
      valid <= sts.valid;
      base  <= W'(1);
      flat  <= '0;
      for (int d = 0; d < ND; d++) begin
        size[d] <= '0;
        offs[d] <= '0;
      end
    end
    if (cmd.div_load) begin
      rem <= '0;
      quo <= cells[cmd.dim];
    end
    if (cmd.div_step) begin
      rem <= take ? W'(trial - {1'b0, topo[cmd.dim]}) : trial[W-1:0];
      quo <= {quo[W-2:0], take};
    end
    if (cmd.mul_pb) begin
      size[cmd.dim] <= quo + W'(rmd > cur_part);
      offs[cmd.dim] <= mul_q[W-1:0] + ((cur_part < rmd) ? cur_part : rmd);
    end
    if (cmd.mul_bt) flat <= flat + mul_q[W-1:0];
    if (cmd.dim_next) base <= mul_q[W-1:0];
  end

  assign index_valid = valid;
  assign topo_x      = topo[0];
  assign topo_y      = topo[1];
  assign topo_z      = topo[2];
  assign size_x      = size[0];
  assign size_y      = size[1];
  assign size_z      = size[2];
  assign offset_x    = offs[0];
  assign offset_y    = offs[1];
  assign offset_z    = offs[2];
  assign flat_index  = flat;

endmodule

FILE: dv/tb_grid_block_partitioner.sv
module tb_grid_block_partitioner;

  localparam int RUN_LIMIT = 2000000;
  localparam int DATA_W    = gbp_pkg::DATA_W;
  localparam int CFG_IDX_W = gbp_pkg::CFG_IDX_W;

  // One partition answer: topology, per-dimension sizes and offsets.
  typedef struct packed {
    logic                         valid;
    logic [2:0][DATA_W-1:0]       topo;
    logic [2:0][DATA_W-1:0]       size;
    logic [2:0][DATA_W-1:0]       offs;
    logic [DATA_W-1:0]            flat;
  } part_info_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = gbp_pkg::REG_NODE_COUNT;
  logic [DATA_W-1:0] cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [DATA_W-1:0] part_x = '0, part_y = '0, part_z = '0;
  logic              done, index_valid;
  logic [DATA_W-1:0] topo_x, topo_y, topo_z, size_x, size_y, size_z;
  logic [DATA_W-1:0] offset_x, offset_y, offset_z, flat_index;

  grid_block_partitioner DUT (.*);

  always #5 clk = ~clk;

  // Local copy of the configuration registers.
  longint unsigned node_cfg;
  longint unsigned cells_cfg [3];

  part_info_t pending_answers[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int idle_pct = 0;
  int cycles = 0;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Greedy processor grid: grow the smallest dimension that still fits.
  function automatic void grow_topology(output longint unsigned t[3]);
    int k;
    int ord[3];
    int v, j, pick;
    longint unsigned prod;
    for (int d = 0; d < 3; d++) t[d] = 1;
    k = 0;
    while (k < 3) begin
      for (int i = 0; i < 3; i++) ord[i] = i;
      for (int i = 1; i < 3; i++) begin
        v = ord[i];
        j = i;
        while (j > 0 && t[ord[j-1]] > t[v]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = v;
      end
      pick = ord[k];
      prod = 1;
      for (int i = 0; i < 3; i++) prod *= (i == pick) ? t[i] + 1 : t[i];
      if (prod <= node_cfg) begin
        t[pick] += 1;
        k = 0;
      end else begin
        k++;
      end
    end
  endfunction

  // Expected answer for one partition index.
  function automatic part_info_t locate_partition(logic [2:0][DATA_W-1:0] p);
    part_info_t r;
    longint unsigned t[3];
    longint unsigned q, rem, base, flat, pv;
    r = '0;
    grow_topology(t);
    r.valid = 1'b1;
    for (int d = 0; d < 3; d++) begin
      r.topo[d] = t[d][DATA_W-1:0];
      if (p[d] >= t[d]) r.valid = 1'b0;
    end
    if (r.valid) begin
      base = 1;
      flat = 0;
      for (int d = 0; d < 3; d++) begin
        pv = p[d];
        q = cells_cfg[d] / t[d];
        rem = cells_cfg[d] - q * t[d];
        r.size[d] = DATA_W'(q + ((rem > pv) ? 1 : 0));
        r.offs[d] = DATA_W'(q * pv + ((pv < rem) ? pv : rem));
        flat += pv * base;
        base *= t[d];
      end
      r.flat = DATA_W'(flat);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Compare each result beat with the oldest pending answer.
  always @(posedge clk) begin
    part_info_t got, want;
    string dn;
    if (!rst && done) begin
      got.valid = index_valid;
      got.topo = {topo_z, topo_y, topo_x};
      got.size = {size_z, size_y, size_x};
      got.offs = {offset_z, offset_y, offset_x};
      got.flat = flat_index;
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat count", longint'(results_seen + 1),
                        longint'(items_sent));
      end else begin
        want = pending_answers.pop_front();
        if (got.valid !== want.valid) report_mismatch("index_valid", got.valid, want.valid);
        for (int d = 0; d < 3; d++) begin
          dn = (d == 0) ? "x" : (d == 1) ? "y" : "z";
          if (got.topo[d] !== want.topo[d])
            report_mismatch({"topo_", dn}, got.topo[d], want.topo[d]);
          if (got.size[d] !== want.size[d])
            report_mismatch({"size_", dn}, got.size[d], want.size[d]);
          if (got.offs[d] !== want.offs[d])
            report_mismatch({"offset_", dn}, got.offs[d], want.offs[d]);
        end
        if (got.flat !== want.flat) report_mismatch("flat_index", got.flat, want.flat);
      end
      results_seen++;
    end
  end

  // Write one register once the block has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    start = 1'b0;
    while (pending_answers.size() != 0 || busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == gbp_pkg::REG_NODE_COUNT) node_cfg = val;
    else cells_cfg[idx - 1] = val;
  endtask

  task automatic configure(int n, int cx, int cy, int cz);
    write_reg(gbp_pkg::REG_NODE_COUNT, DATA_W'(n));
    write_reg(gbp_pkg::REG_CELLS_X, DATA_W'(cx));
    write_reg(gbp_pkg::REG_CELLS_Y, DATA_W'(cy));
    write_reg(gbp_pkg::REG_CELLS_Z, DATA_W'(cz));
    settings_used++;
  endtask

  // Send one beat; with a chance set by idle_pct, then hold start low for a random gap.
  task automatic send_part(int px, int py, int pz);
    @(negedge clk);
    start = 1'b1;
    part_x = DATA_W'(px);
    part_y = DATA_W'(py);
    part_z = DATA_W'(pz);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_answers.push_back(locate_partition({part_z, part_y, part_x}));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      for (int i = 0; i < 200 && $urandom_range(99) < idle_pct; i++) @(negedge clk);
    end
  endtask

  task automatic test_reset_values();
    send_part(0, 0, 0);
    send_part(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_part(0, 1, 0);
  endtask

  task automatic test_directed();
    // Uneven shares with a remainder, and a zero cell count along z.
    configure(8, 10, 7, 0);
    send_part(0, 0, 0);
    send_part(1, 1, 1);
    send_part(2, 0, 0);
    // Zero nodes leave the grid at one partition.
    configure(0, 5, 5, 5);
    send_part(0, 0, 0);
    send_part(1, 0, 0);
    // More partitions than cells leaves trailing partitions empty.
    configure(64, 3, 2, 1);
    send_part(3, 3, 3);
    send_part(0, 0, 0);
    send_part(2, 1, 0);
    // Largest settings.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_part(0, 0, 0);
    send_part(39, 39, 39);
    send_part(16'hFFFF, 0, 0);
    send_part(0, 16'h8000, 0);
    send_part(0, 0, 16'h7FFF);
    configure(1, 1, 1, 1);
  endtask

  function automatic int pick_value(bit zero_ok);
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return zero_ok ? 0 : 1;
      2, 3: return $urandom_range(16'hFFFF);
      default: return $urandom_range(zero_ok ? 0 : 1, 100);
    endcase
  endfunction

  // Random settings; most beats address an existing partition.
  task automatic test_random(int pct, int rounds);
    longint unsigned t[3];
    int p[3];
    idle_pct = pct;
    for (int c = 0; c < rounds; c++) begin
      configure(pick_value(1), pick_value(1), pick_value(1), pick_value(1));
      grow_topology(t);
      for (int n = 0; n < 22; n++) begin
        for (int d = 0; d < 3; d++) begin
          case ($urandom_range(9))
            0: p[d] = $urandom_range(16'hFFFF);
            1: p[d] = t[d];
            default: p[d] = $urandom_range(int'(t[d]) - 1);
          endcase
        end
        send_part(p[0], p[1], p[2]);
      end
    end
  endtask

  initial begin
    node_cfg = 1;
    for (int d = 0; d < 3; d++) cells_cfg[d] = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_directed();
    test_random(0, 6);
    test_random(86, 6);
    test_random(27, 6);
    @(negedge clk);
    start = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d partition lookups checked over %0d register settings", items_sent,
             settings_used);
    $display("%0d result beats, %0d mismatches", results_seen, errors);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
